### rtl/sar_pkg.sv
`timescale 1ns / 1ps

package sar_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 15;

  // operand holds a sum of two samples and its negation
  localparam int OP_W   = SAMPLE_BITS + 2;
  // unsigned Q1.F coefficient, wide enough for an exact 1.0
  localparam int COEF_W = COEF_FRAC_BITS + 1;
  localparam int PROD_W = OP_W + COEF_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CODE_W = 5;
  localparam int DATA_W = ((3 * SAMPLE_BITS + 7) / 8) * 8;

  localparam longint Q30_C = 64'd759250125;
  localparam longint Q30_A = 64'd1060521915;
  localparam longint Q30_B = 64'd167969728;

  localparam logic [COEF_W-1:0] COEF_C = COEF_W'(
      (Q30_C + (longint'(1) << (29 - COEF_FRAC_BITS))) >> (30 - COEF_FRAC_BITS));
  localparam logic [COEF_W-1:0] COEF_A = COEF_W'(
      (Q30_A + (longint'(1) << (29 - COEF_FRAC_BITS))) >> (30 - COEF_FRAC_BITS));
  localparam logic [COEF_W-1:0] COEF_B = COEF_W'(
      (Q30_B + (longint'(1) << (29 - COEF_FRAC_BITS))) >> (30 - COEF_FRAC_BITS));
  localparam logic [COEF_W-1:0] COEF_ONE = {1'b1, {COEF_FRAC_BITS{1'b0}}};

  typedef enum logic [CODE_W-1:0] {
    ROT_NONE,
    ROT_YAW_45,
    ROT_YAW_90,
    ROT_YAW_135,
    ROT_YAW_180,
    ROT_YAW_225,
    ROT_YAW_270,
    ROT_YAW_315,
    ROT_ROLL_180,
    ROT_ROLL_180_YAW_90,
    ROT_PITCH_180,
    ROT_ROLL_180_YAW_270,
    ROT_ROLL_90,
    ROT_ROLL_90_YAW_90,
    ROT_ROLL_270,
    ROT_ROLL_270_YAW_90,
    ROT_ROLL_270_YAW_270,
    ROT_PITCH_90,
    ROT_PITCH_270,
    ROT_ROLL_180_PITCH_270,
    ROT_PITCH_90_YAW_180,
    ROT_PITCH_90_ROLL_90,
    ROT_PITCH_90_ROLL_270,
    ROT_PITCH_9_YAW_180
  } rot_code_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [OP_W-1:0]        op_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  // one output axis: op0 * k0 + op1 * k1, in Q.F
  typedef struct packed {
    op_t               op0;
    logic [COEF_W-1:0] k0;
    op_t               op1;
    logic [COEF_W-1:0] k1;
  } axis_term_t;

  // index 0 is x, 1 is y, 2 is z
  typedef axis_term_t [2:0] term_vec_t;
  typedef prod_t      [2:0] prod_vec_t;
  typedef sum_t       [2:0] sum_vec_t;

  typedef struct packed {
    sample_t rz;
    sample_t ry;
    sample_t rx;
    logic    clipped;
  } result_t;

  function automatic axis_term_t direct_term(op_t v);
    axis_term_t t;
    t.op0 = v;
    t.k0  = COEF_ONE;
    t.op1 = '0;
    t.k1  = '0;
    return t;
  endfunction

  function automatic axis_term_t scaled_term(op_t v, logic [COEF_W-1:0] k);
    axis_term_t t;
    t.op0 = v;
    t.k0  = k;
    t.op1 = '0;
    t.k1  = '0;
    return t;
  endfunction

endpackage

### rtl/sar_select.sv
`timescale 1ns / 1ps

module sar_select
  import sar_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  logic      valid_in,
  input  sample_t   x_in,
  input  sample_t   y_in,
  input  sample_t   z_in,
  input  rot_code_t code,
  output logic      valid_out,
  output term_vec_t terms_out
);

  logic      valid_r;
  term_vec_t terms_r;
  term_vec_t terms_nxt;

  op_t xe, ye, ze, nx, ny, nz, sxy, dxy, dyx, nsxy;

  assign xe   = OP_W'(x_in);
  assign ye   = OP_W'(y_in);
  assign ze   = OP_W'(z_in);
  assign nx   = -xe;
  assign ny   = -ye;
  assign nz   = -ze;
  assign sxy  = xe + ye;
  assign dxy  = xe - ye;
  assign dyx  = ye - xe;
  assign nsxy = -sxy;

  // rounding is symmetric, so a negated product equals a product of the negated sum
  always_comb begin
    terms_nxt[0] = direct_term(xe);
    terms_nxt[1] = direct_term(ye);
    terms_nxt[2] = direct_term(ze);
    case (code)
      ROT_YAW_45: begin
        terms_nxt[0] = scaled_term(dxy, COEF_C);
        terms_nxt[1] = scaled_term(sxy, COEF_C);
      end
      ROT_YAW_90: begin
        terms_nxt[0] = direct_term(ny);
        terms_nxt[1] = direct_term(xe);
      end
      ROT_YAW_135: begin
        terms_nxt[0] = scaled_term(nsxy, COEF_C);
        terms_nxt[1] = scaled_term(dxy, COEF_C);
      end
      ROT_YAW_180: begin
        terms_nxt[0] = direct_term(nx);
        terms_nxt[1] = direct_term(ny);
      end
      ROT_YAW_225: begin
        terms_nxt[0] = scaled_term(dyx, COEF_C);
        terms_nxt[1] = scaled_term(nsxy, COEF_C);
      end
      ROT_YAW_270: begin
        terms_nxt[0] = direct_term(ye);
        terms_nxt[1] = direct_term(nx);
      end
      ROT_YAW_315: begin
        terms_nxt[0] = scaled_term(sxy, COEF_C);
        terms_nxt[1] = scaled_term(dyx, COEF_C);
      end
      ROT_ROLL_180: begin
        terms_nxt[1] = direct_term(ny);
        terms_nxt[2] = direct_term(nz);
      end
      ROT_ROLL_180_YAW_90: begin
        terms_nxt[0] = direct_term(ye);
        terms_nxt[1] = direct_term(xe);
        terms_nxt[2] = direct_term(nz);
      end
      ROT_PITCH_180: begin
        terms_nxt[0] = direct_term(nx);
        terms_nxt[2] = direct_term(nz);
      end
      ROT_ROLL_180_YAW_270: begin
        terms_nxt[0] = direct_term(ny);
        terms_nxt[1] = direct_term(nx);
        terms_nxt[2] = direct_term(nz);
      end
      ROT_ROLL_90: begin
        terms_nxt[1] = direct_term(nz);
        terms_nxt[2] = direct_term(ye);
      end
      ROT_ROLL_90_YAW_90: begin
        terms_nxt[0] = direct_term(ze);
        terms_nxt[1] = direct_term(xe);
        terms_nxt[2] = direct_term(ye);
      end
      ROT_ROLL_270: begin
        terms_nxt[1] = direct_term(ze);
        terms_nxt[2] = direct_term(ny);
      end
      ROT_ROLL_270_YAW_90: begin
        terms_nxt[0] = direct_term(nz);
        terms_nxt[1] = direct_term(xe);
        terms_nxt[2] = direct_term(ny);
      end
      ROT_ROLL_270_YAW_270: begin
        terms_nxt[0] = direct_term(ze);
        terms_nxt[1] = direct_term(nx);
        terms_nxt[2] = direct_term(ny);
      end
      ROT_PITCH_90: begin
        terms_nxt[0] = direct_term(ze);
        terms_nxt[2] = direct_term(nx);
      end
      ROT_PITCH_270: begin
        terms_nxt[0] = direct_term(nz);
        terms_nxt[2] = direct_term(xe);
      end
      ROT_ROLL_180_PITCH_270, ROT_PITCH_90_YAW_180: begin
        terms_nxt[0] = direct_term(ze);
        terms_nxt[1] = direct_term(ny);
        terms_nxt[2] = direct_term(xe);
      end
      ROT_PITCH_90_ROLL_90: begin
        terms_nxt[0] = direct_term(ye);
        terms_nxt[1] = direct_term(nz);
        terms_nxt[2] = direct_term(nx);
      end
      ROT_PITCH_90_ROLL_270: begin
        terms_nxt[0] = direct_term(ny);
        terms_nxt[1] = direct_term(ze);
        terms_nxt[2] = direct_term(nx);
      end
      ROT_PITCH_9_YAW_180: begin
        terms_nxt[0].op0 = nx;
        terms_nxt[0].k0  = COEF_A;
        terms_nxt[0].op1 = nz;
        terms_nxt[0].k1  = COEF_B;
        terms_nxt[1]     = direct_term(ny);
        terms_nxt[2].op0 = nx;
        terms_nxt[2].k0  = COEF_B;
        terms_nxt[2].op1 = ze;
        terms_nxt[2].k1  = COEF_A;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      terms_r <= terms_nxt;
    end
  end

  assign valid_out = valid_r;
  assign terms_out = terms_r;

endmodule

### rtl/sar_mac.sv
`timescale 1ns / 1ps

module sar_mac
  import sar_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  logic      valid_in,
  input  term_vec_t terms_in,
  output logic      valid_out,
  output sum_vec_t  sums_out
);

  logic      prod_valid_r;
  prod_vec_t p0_r, p1_r, p0_nxt, p1_nxt;
  logic      sum_valid_r;
  sum_vec_t  sum_r, sum_nxt;

  logic signed [COEF_W:0] k0_s [3];
  logic signed [COEF_W:0] k1_s [3];

  // multiply stage: two constant-coefficient products per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k0_s[i]   = $signed({1'b0, terms_in[i].k0});
      k1_s[i]   = $signed({1'b0, terms_in[i].k1});
      p0_nxt[i] = terms_in[i].op0 * k0_s[i];
      p1_nxt[i] = terms_in[i].op1 * k1_s[i];
    end
  end

  // add stage
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = SUM_W'(p0_r[i]) + SUM_W'(p1_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      sum_valid_r  <= 1'b0;
    end else if (advance) begin
      prod_valid_r <= valid_in;
      sum_valid_r  <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign valid_out = sum_valid_r;
  assign sums_out  = sum_r;

endmodule

### rtl/sar_round.sv
`timescale 1ns / 1ps

module sar_round
  import sar_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     advance,
  input  logic     valid_in,
  input  sum_vec_t sums_in,
  output logic     valid_out,
  output result_t  result_out
);

  localparam sum_t HALF   = SUM_W'(longint'(1) << (COEF_FRAC_BITS - 1));
  localparam sum_t SAT_HI = SUM_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam sum_t SAT_LO = -SAT_HI - SUM_W'(1);

  logic    valid_r;
  result_t result_r, result_nxt;

  sum_t    biased  [3];
  sum_t    rounded [3];
  sample_t sat_val [3];
  logic    clip    [3];

  // round half away from zero: bias by half, less one below zero, then shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      biased[i]  = sums_in[i] + HALF - SUM_W'(sums_in[i][SUM_W-1]);
      rounded[i] = biased[i] >>> COEF_FRAC_BITS;
      if (rounded[i] > SAT_HI) begin
        sat_val[i] = SAT_HI[SAMPLE_BITS-1:0];
        clip[i]    = 1'b1;
      end else if (rounded[i] < SAT_LO) begin
        sat_val[i] = SAT_LO[SAMPLE_BITS-1:0];
        clip[i]    = 1'b1;
      end else begin
        sat_val[i] = rounded[i][SAMPLE_BITS-1:0];
        clip[i]    = 1'b0;
      end
    end
    result_nxt.rx      = sat_val[0];
    result_nxt.ry      = sat_val[1];
    result_nxt.rz      = sat_val[2];
    result_nxt.clipped = clip[0] | clip[1] | clip[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign valid_out  = valid_r;
  assign result_out = result_r;

endmodule

### rtl/sar_skid.sv
`timescale 1ns / 1ps

module sar_skid
  import sar_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_valid,
  input  result_t up_data,
  output logic    up_ready,
  output logic    dn_valid,
  output result_t dn_data,
  input  logic    dn_ready
);

  logic    main_valid_r;
  result_t main_r;
  logic    skid_valid_r;
  result_t skid_r;
  logic    main_free;

  assign main_free = dn_ready | ~main_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= up_valid;
      end
    end else if (up_valid && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_r <= skid_valid_r ? skid_r : up_data;
    end
    if (!main_free && !skid_valid_r) begin
      skid_r <= up_data;
    end
  end

  assign up_ready = ~skid_valid_r;
  assign dn_valid = main_valid_r;
  assign dn_data  = main_r;

endmodule

### rtl/sensor_axis_rotation.sv
`timescale 1ns / 1ps
// Sensor axis rotation: remaps one signed three-axis sample per beat into the
// board frame under the mounting orientation held in the rotation code register.
// Channels: in_* carries a sample (x, y, z), out_* carries the rotated sample
// with its clipped flag on out_tuser; cfg_wr_en/cfg_wr_data load the code.
// Write the code only while no beat is in flight.
// Throughput: one beat per cycle while out_tready stays high. The four pipeline
// stages (select, multiply, add, round and saturate) all move together under one
// advance. Path: the select register loads at the accepting edge; the multiply,
// add and round registers and the output register of the skid buffer follow it
// in that order.
// Stall: when out_tready is low the output beat holds, one more result lands
// in the skid register, and in_tready drops on the next cycle, straight from a
// flop. Up to six beats can be in flight; nothing is lost or repeated.
// Reset (rst_n low, synchronous): clear all valid bits and set the code to
// pass-through; in_tready is high from the first cycle after reset.
module sensor_axis_rotation
  import sar_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CODE_W-1:0] cfg_wr_data,   // rotation_code
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,      // sample_x, sample_y, sample_z
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,     // rotated_x, rotated_y, rotated_z
  output logic              out_tuser      // clipped
);

  rot_code_t code_r;

  logic      advance;
  logic      s1_valid;
  term_vec_t s1_terms;
  logic      s3_valid;
  sum_vec_t  s3_sums;
  logic      s4_valid;
  result_t   s4_result;
  result_t   out_result;

  // orientation register; only the low five bits exist
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= ROT_NONE;
    end else if (cfg_wr_en) begin
      code_r <= rot_code_t'(cfg_wr_data);
    end
  end

  // whole pipeline advances whenever the skid buffer has room
  assign in_tready = advance;

  sar_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .valid_in  (in_tvalid),
    .x_in      (in_tdata[SAMPLE_BITS-1:0]),
    .y_in      (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .z_in      (in_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .code      (code_r),
    .valid_out (s1_valid),
    .terms_out (s1_terms)
  );

  // products, then sums of product pairs
  sar_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .valid_in  (s1_valid),
    .terms_in  (s1_terms),
    .valid_out (s3_valid),
    .sums_out  (s3_sums)
  );

  // drop the fraction with rounding and saturate each axis
  sar_round u_round (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .valid_in   (s3_valid),
    .sums_in    (s3_sums),
    .valid_out  (s4_valid),
    .result_out (s4_result)
  );

  sar_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s4_valid),
    .up_data  (s4_result),
    .up_ready (advance),
    .dn_valid (out_tvalid),
    .dn_data  (out_result),
    .dn_ready (out_tready)
  );

  // pack x in the lowest bits, zero fill up to whole bytes
  assign out_tdata = DATA_W'({out_result.rz, out_result.ry, out_result.rx});
  assign out_tuser = out_result.clipped;

endmodule

### rtl/sar_checker.sv
`timescale 1ns / 1ps

module sar_checker
  import sar_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              cfg_wr_en,
  input logic [CODE_W-1:0] cfg_wr_data,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [DATA_W-1:0] in_tdata,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic              out_tuser
);

  // four pipeline stages plus output and skid registers
  localparam logic [3:0] MAX_IN_FLIGHT = 4'd6;

  logic [3:0] in_flight_r;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_tvalid & in_tready;
  assign out_beat = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_flight_r <= '0;
    end else begin
      in_flight_r <= in_flight_r + 4'(in_beat) - 4'(out_beat);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed under stall");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input ready dropped without an output stall");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> in_flight_r != 4'd0)
    else $error("output beat with no input beat behind it");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_flight_r <= MAX_IN_FLIGHT)
    else $error("more beats in flight than the pipeline can hold");

endmodule

bind sensor_axis_rotation sar_checker u_sar_checker (.*);
